// ----- rtl/gtits_pkg.sv -----
// ----------------------------------------------------------------------------
// gtits_pkg
// Shared types and constants for the fix-time to timestamp converter: scale
// factors, month start days, leap thresholds and cumulative corrections.
// ----------------------------------------------------------------------------
package gtits_pkg;

	typedef logic signed [43:0] ms_t;
	typedef logic [29:0]        corr_t;

	localparam int LEAP_STEPS = 17;

	localparam logic signed [27:0] MS_PER_DAY  = 28'sd86400000;
	localparam logic        [21:0] MS_PER_HOUR = 22'd3600000;
	localparam logic        [15:0] MS_PER_MIN  = 16'd60000;
	localparam logic        [9:0]  MS_PER_SEC  = 10'd1000;
	localparam logic        [3:0]  MS_PER_CS   = 4'd10;

	localparam ms_t BAD_MONTH_MS = -44'sd4398046511103;

	localparam logic [8:0] MONTH_START [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	// Thresholds as seen by the uncorrected total: each one is the original
	// limit minus the corrections of all steps below it. Strictly increasing.
	localparam ms_t LEAP_ADJ [LEAP_STEPS] = '{
		44'sd5097600000,    44'sd63072000000,   44'sd131241600000,
		44'sd157680000000,  44'sd257385600000,  44'sd267926400000,
		44'sd362534400000,  44'sd383529600000,  44'sd409968000000,
		44'sd509673600000,  44'sd635817600000,  44'sd761961600000,
		44'sd888105600000,  44'sd1014249600000, 44'sd1140393600000,
		44'sd1266537600000, 44'sd1392681600000
	};

	// Total correction once the lowest n thresholds have been passed.
	localparam corr_t LEAP_CUM [LEAP_STEPS + 1] = '{
		30'd0,         30'd86400000,  30'd86401000,  30'd172801000,
		30'd172802000, 30'd259202000, 30'd259203000, 30'd259204000,
		30'd345604000, 30'd345605000, 30'd432005000, 30'd518405000,
		30'd604805000, 30'd691205000, 30'd777605000, 30'd864005000,
		30'd950405000, 30'd1036805000
	};

endpackage

// ----- rtl/gtits_leap_corr.sv -----
// ----------------------------------------------------------------------------
// gtits_leap_corr
// Leap day and leap second correction: compares the base total against all
// thresholds in parallel and picks the cumulative correction.
// ----------------------------------------------------------------------------
module gtits_leap_corr (
	input  gtits_pkg::ms_t   base_ms,
	output gtits_pkg::corr_t corr
);

	logic [gtits_pkg::LEAP_STEPS:0] pass;

	always_comb begin
		pass = '0;
		for (int k = 0; k < gtits_pkg::LEAP_STEPS; k++) begin
			pass[k] = (base_ms >= gtits_pkg::LEAP_ADJ[k]);
		end
	end

	// Thresholds increase, so pass is a thermometer code; its top edge picks
	// the correction.
	always_comb begin
		corr = '0;
		for (int k = 0; k < gtits_pkg::LEAP_STEPS; k++) begin
			if (pass[k] && !pass[k + 1]) begin
				corr = corr | gtits_pkg::LEAP_CUM[k + 1];
			end
		end
	end

endmodule

// ----- rtl/gnss_time_to_its_timestamp_top.sv -----
// ----------------------------------------------------------------------------
// gnss_time_to_its_timestamp_top
// Converts the two-digit date and UTC time of a GNSS fix into milliseconds
// since the start of 2004, with leap day and leap second correction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel item_valid / item_stall carries one fix per item: the
//   fix_valid flag and the year, month, day, hour, minute, second and
//   centisecond values. Output channel result_valid / result_stall carries
//   timestamp_ms, one result per input item, in order.
//   Throughput: one item per cycle while result_stall is low. The work runs
//   through five register stages (input, month lookup and constant
//   products, day scaling and partial sums, threshold compare and time sum,
//   output with the leap correction added).
//   A month outside 1 to 12 gives the bad-month sentinel plus the day and
//   time terms; fix_valid low gives zero.
//   Reset (arst_n low) empties all stages; no result is pending afterward.
//   While result_stall is high the output holds; empty stages still take
//   new items, and item_stall rises only once every stage is full.
// ----------------------------------------------------------------------------
module gnss_time_to_its_timestamp_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic                 fix_valid,
	input  logic [6:0]           year_two_digit,
	input  logic [6:0]           month,
	input  logic [6:0]           day,
	input  logic [6:0]           hour,
	input  logic [6:0]           minute,
	input  logic [6:0]           second,
	input  logic [6:0]           centisecond,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic signed [43:0]   timestamp_ms
);

	logic v_s1, v_s2, v_s3, v_s4, v_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_q;

	assign rdy_q  = !v_q  || !result_stall;
	assign rdy_s4 = !v_s4 || rdy_q;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign item_stall   = !rdy_s1;
	assign result_valid = v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= item_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_q)  v_q  <= v_s4;
		end
	end

	// Stage 1: input register
	logic       fix_s1;
	logic [6:0] yr_s1, mon_s1, day_s1, hr_s1, mn_s1, sc_s1, cs_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			fix_s1 <= fix_valid;
			yr_s1  <= year_two_digit;
			mon_s1 <= month;
			day_s1 <= day;
			hr_s1  <= hour;
			mn_s1  <= minute;
			sc_s1  <= second;
			cs_s1  <= centisecond;
		end
	end

	// Stage 2: day count, month check, constant products of the time fields
	logic               bad_d;
	logic [8:0]         msd_d;
	logic signed [16:0] yr_off_d, days_d;
	logic signed [7:0]  dm1_d;
	logic signed [35:0] p_day_d;
	logic [28:0]        p_hr_d;
	logic [22:0]        p_mn_d;
	logic [16:0]        p_sc_d;
	logic [10:0]        p_cs_d;

	always_comb begin
		bad_d    = !(mon_s1 inside {[7'd1:7'd12]});
		msd_d    = bad_d ? 9'd0 : gtits_pkg::MONTH_START[4'(mon_s1 - 7'd1)];
		yr_off_d = $signed({10'd0, yr_s1}) - 17'sd4;
		days_d   = 17'(yr_off_d * 17'sd365) + $signed({8'd0, msd_d});
		dm1_d    = $signed({1'b0, day_s1}) - 8'sd1;
		p_day_d  = dm1_d * gtits_pkg::MS_PER_DAY;
		p_hr_d   = hr_s1 * gtits_pkg::MS_PER_HOUR;
		p_mn_d   = mn_s1 * gtits_pkg::MS_PER_MIN;
		p_sc_d   = sc_s1 * gtits_pkg::MS_PER_SEC;
		p_cs_d   = cs_s1 * gtits_pkg::MS_PER_CS;
	end

	logic               fix_s2, bad_s2;
	logic signed [16:0] days_s2;
	logic signed [35:0] p_day_s2;
	logic [28:0]        p_hr_s2;
	logic [22:0]        p_mn_s2;
	logic [16:0]        p_sc_s2;
	logic [10:0]        p_cs_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			fix_s2   <= fix_s1;
			bad_s2   <= bad_d;
			days_s2  <= days_d;
			p_day_s2 <= p_day_d;
			p_hr_s2  <= p_hr_d;
			p_mn_s2  <= p_mn_d;
			p_sc_s2  <= p_sc_d;
			p_cs_s2  <= p_cs_d;
		end
	end

	// Stage 3: day count to ms (or sentinel), partial sums of the time terms
	logic signed [44:0] base_prod;
	gtits_pkg::ms_t     base_d;
	logic signed [36:0] tail_a_d;
	logic [23:0]        tail_b_d;

	always_comb begin
		base_prod = days_s2 * gtits_pkg::MS_PER_DAY;
		base_d    = bad_s2 ? gtits_pkg::BAD_MONTH_MS : base_prod[43:0];
		tail_a_d  = 37'(p_day_s2) + $signed({8'd0, p_hr_s2});
		tail_b_d  = 24'(p_mn_s2) + 24'(p_sc_s2) + 24'(p_cs_s2);
	end

	logic               fix_s3;
	gtits_pkg::ms_t     base_s3;
	logic signed [36:0] tail_a_s3;
	logic [23:0]        tail_b_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			fix_s3    <= fix_s2;
			base_s3   <= base_d;
			tail_a_s3 <= tail_a_d;
			tail_b_s3 <= tail_b_d;
		end
	end

	// Stage 4: leap correction from the base total, base plus time terms
	gtits_pkg::corr_t leap_corr;
	gtits_pkg::ms_t   sum_d;

	gtits_leap_corr u_leap (
		.base_ms (base_s3),
		.corr    (leap_corr)
	);

	assign sum_d = base_s3 + 44'(tail_a_s3) + $signed({20'd0, tail_b_s3});

	logic             fix_s4;
	gtits_pkg::ms_t   sum_s4;
	gtits_pkg::corr_t corr_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			fix_s4  <= fix_s3;
			sum_s4  <= sum_d;
			corr_s4 <= leap_corr;
		end
	end

	// Stage 5: output register
	always_ff @(posedge clk) begin
		if (rdy_q) begin
			timestamp_ms <= fix_s4 ? sum_s4 + $signed({14'd0, corr_s4}) : '0;
		end
	end

	// Assertions
	a_no_fix_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && rdy_q && !fix_s4) |=> (timestamp_ms == '0))
		else $error("result of an item without fix is not zero");

	a_neg_no_corr: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && base_s3 < 0) |-> (leap_corr == '0))
		else $error("leap correction applied to a negative total");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_q && result_stall))
		else $error("input stalled while the pipeline has room");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q && result_stall) |=> (v_q && $stable(timestamp_ms)))
		else $error("stalled result changed");

endmodule
